// ===== design/pso_pkg.sv =====
// Shared types and constants for the particle swarm update pipeline.
package pso_pkg;

  localparam logic [2:0] CFG_ACCEL_P  = 3'd0;
  localparam logic [2:0] CFG_ACCEL_S  = 3'd1;
  localparam logic [2:0] CFG_INER_MAX = 3'd2;
  localparam logic [2:0] CFG_INER_MIN = 3'd3;
  localparam logic [2:0] CFG_STEPS    = 3'd4;
  localparam logic [2:0] CFG_WRAP     = 3'd5;

  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_BELOW = 2'd1;
  localparam logic [1:0] EV_ABOVE = 2'd2;

  localparam int IDIV_STEPS = 17;
  localparam int MOD_STEPS  = 33;
  localparam int S_IN   = 0;
  localparam int S_RHO  = 1;
  localparam int S_IDIV = 2;
  localparam int S_W    = S_IDIV + IDIV_STEPS;
  localparam int S_MUL  = S_W + 1;
  localparam int S_SUM  = S_MUL + 1;
  localparam int S_POS  = S_SUM + 1;
  localparam int S_MOD  = S_POS + 1;
  localparam int S_FIN  = S_MOD + MOD_STEPS;
  localparam int NSTG   = S_FIN + 1;

  typedef struct packed {
    logic [32:0]        dvd;
    logic [32:0]        rem;
    logic [16:0]        quo;
    logic               neg;
    logic               use_div;
    logic [34:0]        prod_p;
    logic [34:0]        prod_s;
    logic [19:0]        rho_p;
    logic [19:0]        rho_s;
    logic signed [31:0] pos;
    logic signed [31:0] vel;
    logic signed [31:0] pb;
    logic signed [31:0] nb;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    logic signed [32:0] dp;
    logic signed [32:0] dn;
    logic signed [18:0] w;
    logic signed [50:0] t0;
    logic signed [53:0] t1;
    logic signed [53:0] t2;
    logic signed [31:0] nv;
    logic signed [32:0] p;
    logic signed [32:0] span;
    logic [1:0]         ev;
  } pso_word_t;

endpackage

// ===== design/pso_particle_update.sv =====
// Particle swarm velocity and position update, one particle-dimension per word.
//
// Input channel in_*: one word per particle-dimension (step, position,
// velocity, bests, random fractions, bounds). Output channel out_*: the new
// position, new velocity and bound event for that word, in order.
// Configuration channel cfg_*: always ready; write only while no word is in
// flight.
// Throughput: one word per cycle while the output is not stalled. The pipeline
// includes the pipelined inertia divider (17 stages, one quotient bit each)
// and the pipelined wrap remainder unit (33 stages, one dividend bit each).
// Reset: clears all stage valid bits and loads the default coefficients.
// Output stall: the word on the output holds; earlier stages keep advancing
// into empty slots, so input is taken until the pipeline is full.
module pso_particle_update
  import pso_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [15:0]        in_step_index,
  input  logic signed [31:0] in_position,
  input  logic signed [31:0] in_velocity,
  input  logic signed [31:0] in_personal_best,
  input  logic signed [31:0] in_neighbour_best,
  input  logic [16:0]        in_rand_personal,
  input  logic [16:0]        in_rand_social,
  input  logic signed [31:0] in_low_bound,
  input  logic signed [31:0] in_high_bound,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_new_position,
  output logic signed [31:0] out_new_velocity,
  output logic [1:0]         out_bound_event,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  logic [17:0] accel_p_r;
  logic [17:0] accel_s_r;
  logic [16:0] iner_max_r;
  logic [16:0] iner_min_r;
  logic [15:0] steps_r;
  logic        wrap_r;

  logic [17:0] steps3;
  logic [15:0] dec;

  pso_word_t        st_r [NSTG];
  pso_word_t        stg_nxt [NSTG];
  logic [NSTG-1:0]  v_r;
  logic [NSTG-1:0]  rdy;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_p_r  <= 18'd98042;
      accel_s_r  <= 18'd98042;
      iner_max_r <= 17'd47828;
      iner_min_r <= 17'd19661;
      steps_r    <= 16'd500;
      wrap_r     <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ACCEL_P:  accel_p_r  <= cfg_data[17:0];
        CFG_ACCEL_S:  accel_s_r  <= cfg_data[17:0];
        CFG_INER_MAX: iner_max_r <= cfg_data[16:0];
        CFG_INER_MIN: iner_min_r <= cfg_data[16:0];
        CFG_STEPS:    steps_r    <= cfg_data[15:0];
        CFG_WRAP:     wrap_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign steps3 = {2'b00, steps_r} + {1'b0, steps_r, 1'b0};
  assign dec    = steps3[17:2];

  function automatic pso_word_t f_rho(pso_word_t a);
    pso_word_t r;
    logic [35:0] sp;
    logic [35:0] ss;
    r  = a;
    sp = {1'b0, a.prod_p} + 36'd32768;
    ss = {1'b0, a.prod_s} + 36'd32768;
    r.rho_p = sp[35:16];
    r.rho_s = ss[35:16];
    r.dp = {a.pb[31], a.pb} - {a.pos[31], a.pos};
    r.dn = {a.nb[31], a.nb} - {a.pos[31], a.pos};
    return r;
  endfunction

  function automatic pso_word_t f_idiv(pso_word_t a, logic [15:0] d);
    pso_word_t r;
    logic [16:0] t;
    logic [16:0] s;
    r = a;
    t = {a.rem[15:0], a.dvd[16]};
    s = t - {1'b0, d};
    if (t >= {1'b0, d}) begin
      r.rem = {17'd0, s[15:0]};
      r.quo = {a.quo[15:0], 1'b1};
    end else begin
      r.rem = {17'd0, t[15:0]};
      r.quo = {a.quo[15:0], 1'b0};
    end
    r.dvd = {a.dvd[31:0], 1'b0};
    return r;
  endfunction

  function automatic pso_word_t f_w(pso_word_t a, logic [16:0] wmin);
    pso_word_t r;
    logic signed [18:0] q19;
    logic signed [18:0] m19;
    r   = a;
    q19 = {2'b00, a.quo};
    m19 = {2'b00, wmin};
    if (!a.use_div) r.w = m19;
    else if (a.neg) r.w = m19 - q19;
    else r.w = m19 + q19;
    r.t1 = $signed({1'b0, a.rho_p}) * a.dp;
    r.t2 = $signed({1'b0, a.rho_s}) * a.dn;
    return r;
  endfunction

  function automatic pso_word_t f_mul(pso_word_t a);
    pso_word_t r;
    r    = a;
    r.t0 = a.w * a.vel;
    return r;
  endfunction

  function automatic pso_word_t f_sum(pso_word_t a);
    pso_word_t r;
    logic signed [50:0] x0;
    logic signed [53:0] x1;
    logic signed [53:0] x2;
    logic signed [39:0] sum;
    r   = a;
    x0  = a.t0 + 51'sd32768;
    x1  = a.t1 + 54'sd32768;
    x2  = a.t2 + 54'sd32768;
    sum = $signed(x0[50:16]) + $signed(x1[53:16]) + $signed(x2[53:16]);
    if (sum > 40'sd2147483647) r.nv = 32'sh7fffffff;
    else if (sum < -40'sd2147483648) r.nv = 32'sh80000000;
    else r.nv = sum[31:0];
    return r;
  endfunction

  function automatic pso_word_t f_pos(pso_word_t a);
    pso_word_t r;
    logic signed [32:0] p;
    logic signed [32:0] lo33;
    logic signed [32:0] hi33;
    r    = a;
    p    = {a.nv[31], a.nv} + {a.pos[31], a.pos};
    lo33 = {a.lo[31], a.lo};
    hi33 = {a.hi[31], a.hi};
    r.p    = p;
    r.span = hi33 - lo33;
    r.rem  = '0;
    if (p < lo33) begin
      r.ev  = EV_BELOW;
      r.dvd = lo33 - p;
    end else if (p > hi33) begin
      r.ev  = EV_ABOVE;
      r.dvd = p - hi33;
    end else begin
      r.ev  = EV_NONE;
      r.dvd = '0;
    end
    return r;
  endfunction

  function automatic pso_word_t f_mod(pso_word_t a);
    pso_word_t r;
    logic [33:0] t;
    logic [33:0] s;
    r = a;
    t = {a.rem, a.dvd[32]};
    s = t - {1'b0, a.span};
    if (t >= {1'b0, a.span}) r.rem = s[32:0];
    else r.rem = t[32:0];
    r.dvd = {a.dvd[31:0], 1'b0};
    return r;
  endfunction

  function automatic pso_word_t f_fin(pso_word_t a, logic wrap);
    pso_word_t r;
    logic signed [32:0] lo33;
    logic signed [32:0] hi33;
    logic               wr;
    r    = a;
    lo33 = {a.lo[31], a.lo};
    hi33 = {a.hi[31], a.hi};
    wr   = wrap && (a.span > 33'sd0);
    unique case (a.ev)
      EV_BELOW: r.p = wr ? hi33 - $signed(a.rem) : lo33;
      EV_ABOVE: r.p = wr ? lo33 + $signed(a.rem) : hi33;
      default:  r.p = a.p;
    endcase
    if (a.ev != EV_NONE) r.nv = '0;
    return r;
  endfunction

  always_comb begin
    logic signed [17:0] diff;
    logic [17:0]        mag;
    logic [15:0]        num;
    logic [32:0]        prod;
    diff = $signed({1'b0, iner_max_r}) - $signed({1'b0, iner_min_r});
    mag  = diff[17] ? 18'(-diff) : diff;
    num  = dec - in_step_index;
    prod = 33'(mag[16:0]) * 33'(num);
    stg_nxt[S_IN]         = '0;
    stg_nxt[S_IN].dvd     = prod;
    stg_nxt[S_IN].rem     = {17'd0, prod[32:17]};
    stg_nxt[S_IN].neg     = diff[17];
    stg_nxt[S_IN].use_div = (in_step_index <= dec) && (dec != 16'd0);
    stg_nxt[S_IN].prod_p  = 35'(accel_p_r) * 35'(in_rand_personal);
    stg_nxt[S_IN].prod_s  = 35'(accel_s_r) * 35'(in_rand_social);
    stg_nxt[S_IN].pos     = in_position;
    stg_nxt[S_IN].vel     = in_velocity;
    stg_nxt[S_IN].pb      = in_personal_best;
    stg_nxt[S_IN].nb      = in_neighbour_best;
    stg_nxt[S_IN].lo      = in_low_bound;
    stg_nxt[S_IN].hi      = in_high_bound;
    for (int k = 1; k < NSTG; k++) begin
      if (k == S_RHO) stg_nxt[k] = f_rho(st_r[k-1]);
      else if (k < S_W) stg_nxt[k] = f_idiv(st_r[k-1], dec);
      else if (k == S_W) stg_nxt[k] = f_w(st_r[k-1], iner_min_r);
      else if (k == S_MUL) stg_nxt[k] = f_mul(st_r[k-1]);
      else if (k == S_SUM) stg_nxt[k] = f_sum(st_r[k-1]);
      else if (k == S_POS) stg_nxt[k] = f_pos(st_r[k-1]);
      else if (k < S_FIN) stg_nxt[k] = f_mod(st_r[k-1]);
      else stg_nxt[k] = f_fin(st_r[k-1], wrap_r);
    end
  end

  always_comb begin
    rdy[NSTG-1] = !v_r[NSTG-1] || !out_stall;
    for (int k = NSTG - 2; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  assign in_stall = !rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= in_valid;
      for (int k = 1; k < NSTG; k++) begin
        if (rdy[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NSTG; k++) begin
      if (rdy[k]) st_r[k] <= stg_nxt[k];
    end
  end

  assign out_valid        = v_r[NSTG-1];
  assign out_new_position = st_r[NSTG-1].p[31:0];
  assign out_new_velocity = st_r[NSTG-1].nv;
  assign out_bound_event  = st_r[NSTG-1].ev;

endmodule

// ===== design/pso_chk.sv =====
// Port-level assertions for the particle swarm update block, bound to the top level.
module pso_chk
  import pso_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] out_new_position,
  input logic signed [31:0] out_new_velocity,
  input logic [1:0]         out_bound_event
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_new_position))
    else $error("stalled output word changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_event_vel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_bound_event != EV_NONE) |-> out_new_velocity == 32'sd0)
    else $error("velocity not zeroed on bound event");

  a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled while output slot empty");

endmodule

bind pso_particle_update pso_chk u_pso_chk (.*);

// ===== dv/testbench.sv =====
// Self-checking testbench for the particle swarm velocity and position update pipeline.
`timescale 1ns / 100ps

module testbench;
  import pso_pkg::*;

  typedef struct {
    logic [15:0] step;
    logic signed [31:0] pos, vel, pb, nb, lo, hi;
    logic [16:0] rp, rs;
  } pso_in_t;

  typedef struct {
    logic signed [31:0] npos, nvel;
    logic [1:0] ev;
  } pso_res_t;

  localparam int LATENCY = 60;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk, rst_n;
  logic in_valid, in_stall;
  logic [15:0] in_step_index;
  logic signed [31:0] in_position, in_velocity, in_personal_best, in_neighbour_best;
  logic [16:0] in_rand_personal, in_rand_social;
  logic signed [31:0] in_low_bound, in_high_bound;
  logic out_valid, out_stall;
  logic signed [31:0] out_new_position, out_new_velocity;
  logic [1:0] out_bound_event;
  logic cfg_valid, cfg_ready;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;

  logic [17:0] m_accel_p, m_accel_s;
  logic [16:0] m_iner_max, m_iner_min;
  logic [15:0] m_steps;
  logic m_wrap;

  pso_res_t expected_q[$];
  int fail_count = 0;
  int idle_cycles = 0;
  bit hold_off = 0;

  pso_particle_update u_top (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic longint round_half_up(longint x);
    return (x + 32768) >>> 16;
  endfunction

  function automatic longint sat_word(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic pso_res_t predict_update(pso_in_t d);
    pso_res_t r;
    longint dec, w, rho_p, rho_s, nv, p, span, lo, hi, pos;
    logic [1:0] ev;
    lo = d.lo;
    hi = d.hi;
    pos = d.pos;
    dec = (3 * longint'(m_steps)) / 4;
    if (d.step <= dec && dec > 0)
      w = longint'(m_iner_min) + ((longint'(m_iner_max) - longint'(m_iner_min))
          * (dec - longint'(d.step))) / dec;
    else
      w = m_iner_min;
    rho_p = round_half_up(longint'(m_accel_p) * longint'(d.rp));
    rho_s = round_half_up(longint'(m_accel_s) * longint'(d.rs));
    nv = round_half_up(w * longint'(d.vel)) + round_half_up(rho_p * (longint'(d.pb) - pos))
         + round_half_up(rho_s * (longint'(d.nb) - pos));
    nv = sat_word(nv);
    p = pos + nv;
    span = hi - lo;
    ev = EV_NONE;
    if (p < lo) begin
      ev = EV_BELOW;
      if (m_wrap && span > 0) p = hi - ((lo - p) % span);
      else p = lo;
    end else if (p > hi) begin
      ev = EV_ABOVE;
      if (m_wrap && span > 0) p = lo + ((p - hi) % span);
      else p = hi;
    end
    if (ev != EV_NONE) nv = 0;
    r.npos = sat_word(p);
    r.nvel = nv;
    r.ev = ev;
    return r;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    case (idx)
      CFG_ACCEL_P: m_accel_p = val[17:0];
      CFG_ACCEL_S: m_accel_s = val[17:0];
      CFG_INER_MAX: m_iner_max = val[16:0];
      CFG_INER_MIN: m_iner_min = val[16:0];
      CFG_STEPS: m_steps = val[15:0];
      CFG_WRAP: m_wrap = val[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_word(pso_in_t d, bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : ($urandom_range(0, 3) == 0 ? $urandom_range(0, 15) : 0);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_step_index <= d.step;
    in_position <= d.pos;
    in_velocity <= d.vel;
    in_personal_best <= d.pb;
    in_neighbour_best <= d.nb;
    in_rand_personal <= d.rp;
    in_rand_social <= d.rs;
    in_low_bound <= d.lo;
    in_high_bound <= d.hi;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_q.push_back(predict_update(d));
  endtask

  task automatic drain_pipe();
    in_valid <= 0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(0, 1) ? 32'(int'($urandom_range(0, 2000)) - 1000) : 32'h0;
      3: return 32'($signed($urandom()) >>> $urandom_range(8, 20));
      default: return $urandom();
    endcase
  endfunction

  function automatic pso_in_t rand_item(bit wide);
    pso_in_t d;
    logic signed [31:0] a, b, c;
    d.step = $urandom_range(0, 3) == 0 ? 16'($urandom()) : 16'($urandom_range(0, 600));
    d.rp = $urandom_range(0, 7) == 0 ? 17'($urandom()) : 17'($urandom_range(0, 65536));
    d.rs = $urandom_range(0, 7) == 0 ? 17'($urandom()) : 17'($urandom_range(0, 65536));
    if (wide) begin
      d.pos = rand_word();
      d.vel = rand_word();
      d.pb = rand_word();
      d.nb = rand_word();
      d.lo = rand_word();
      d.hi = rand_word();
    end else begin
      c = 32'(int'($urandom_range(0, 20)) - 10) <<< 16;
      a = c - 32'($urandom_range(1, 40) << 16);
      b = c + 32'($urandom_range(1, 40) << 16);
      d.lo = a;
      d.hi = b;
      d.pos = c + 32'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
      d.vel = 32'(int'($urandom_range(0, 1 << 22)) - (1 << 21));
      d.pb = c + 32'(int'($urandom_range(0, 1 << 23)) - (1 << 22));
      d.nb = c + 32'(int'($urandom_range(0, 1 << 23)) - (1 << 22));
    end
    return d;
  endfunction

  task automatic test_directed();
    pso_in_t d;
    d = '{step: 0, pos: 0, vel: 32'sh10000, pb: 32'sh20000, nb: -32'sh20000,
          rp: 17'h10000, rs: 17'h10000, lo: -32'sh100000, hi: 32'sh100000};
    send_word(d);
    d.step = 16'hffff; send_word(d);
    d.step = 375; send_word(d);
    d.step = 376; send_word(d);
    d.vel = 32'h7fffffff; d.pos = 32'h7fffffff; d.pb = 32'h80000000; d.nb = 32'h80000000;
    d.lo = 32'h80000000; d.hi = 32'h7fffffff; send_word(d);
    d.vel = 32'h80000000; d.pos = 32'h80000000; d.pb = 32'h7fffffff; d.nb = 32'h7fffffff;
    send_word(d);
    d.rp = 17'h1ffff; d.rs = 0; send_word(d);
    d = '{step: 10, pos: 32'sh50000, vel: 32'sh80000, pb: 32'sh50000, nb: 32'sh50000,
          rp: 0, rs: 0, lo: 0, hi: 32'sh80000};
    send_word(d);
    d.vel = -32'sh100000; send_word(d);
    d.lo = 32'sh80000; d.hi = 32'sh80000; send_word(d);
    d.lo = 32'sh90000; d.hi = 0; send_word(d);
    d.lo = 32'hffffffff; d.hi = 32'hffffffff; d.vel = 0; send_word(d);
    drain_pipe();
  endtask

  task automatic test_wrap_mode();
    pso_in_t d;
    write_reg(CFG_WRAP, 1);
    d = '{step: 10, pos: 32'sh50000, vel: 32'sh280000, pb: 32'sh50000, nb: 32'sh50000,
          rp: 0, rs: 0, lo: 0, hi: 32'sh80000};
    send_word(d);
    d.vel = -32'sh280000; send_word(d);
    d.hi = 0; d.lo = 32'sh80000; send_word(d);
    d.lo = 32'h80000000; d.hi = 32'h80000001; d.pos = 0; d.vel = 32'h7fffffff;
    send_word(d);
    d.vel = 32'h80000000; send_word(d);
    d.lo = 32'h80000000; d.hi = 32'h7fffffff; d.pos = 32'h7fffffff; d.vel = 32'h7fffffff;
    send_word(d);
    drain_pipe();
  endtask

  task automatic test_random_phase(int count, bit wide);
    repeat (count) send_word(rand_item(wide));
    drain_pipe();
  endtask

  task automatic test_random_configs();
    logic [31:0] cfgs[6][4];
    cfgs = '{'{0, 32'h3ffff, 98042, 32'hffffffff},
             '{0, 32'h3ffff, 65536, 32'hfffc0000},
             '{0, 65536, 32'h1ffff, 47828},
             '{65536, 0, 32'h1ffff, 19661},
             '{2, 3, 32'hffff, 4},
             '{1, 0, 1, 32'hfffffffe}};
    for (int k = 0; k < 4; k++) begin
      for (int r = 0; r < 6; r++) write_reg(3'(r), cfgs[r][k]);
      test_random_phase(150, k[0]);
    end
    write_reg(3'd7, 32'hffffffff);
    write_reg(CFG_STEPS, $urandom_range(2, 65535));
    write_reg(CFG_INER_MAX, $urandom_range(0, 65536));
    write_reg(CFG_INER_MIN, $urandom_range(0, 65536));
    write_reg(CFG_ACCEL_P, $urandom_range(0, 262143));
    write_reg(CFG_ACCEL_S, $urandom_range(0, 262143));
    test_random_phase(250, 0);
  endtask

  task automatic test_backpressure();
    hold_off = 1;
    repeat (150) send_word(rand_item(0), 1);
    hold_off = 0;
    drain_pipe();
    repeat (100) send_word(rand_item($urandom_range(0, 1)));
    drain_pipe();
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result word");
        fail_count++;
      end else begin
        pso_res_t e;
        e = expected_q.pop_front();
        if (out_new_position !== e.npos) begin
          $error("new_position exp %0d got %0d", e.npos, out_new_position);
          fail_count++;
        end
        if (out_new_velocity !== e.nvel) begin
          $error("new_velocity exp %0d got %0d", e.nvel, out_new_velocity);
          fail_count++;
        end
        if (out_bound_event !== e.ev) begin
          $error("bound_event exp %0d got %0d", e.ev, out_bound_event);
          fail_count++;
        end
      end
    end
  end

  initial begin
    int wait_left, hold_left;
    bit hold_seen;
    wait_left = 0;
    hold_left = 0;
    hold_seen = 0;
    out_stall = 0;
    forever begin
      @(posedge clk);
      if (hold_off && !hold_seen) hold_left = 200;
      hold_seen = hold_off;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1;
      end else if (out_valid && !out_stall && wait_left == 0) begin
        wait_left = $urandom_range(0, 3) == 0 ? $urandom_range(0, 15) : 0;
        out_stall <= (wait_left != 0);
      end else if (wait_left > 0) begin
        wait_left--;
        out_stall <= (wait_left != 0);
      end else begin
        out_stall <= 0;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    rst_n = 0;
    in_valid = 0;
    in_step_index = 0;
    in_position = 0;
    in_velocity = 0;
    in_personal_best = 0;
    in_neighbour_best = 0;
    in_rand_personal = 0;
    in_rand_social = 0;
    in_low_bound = 0;
    in_high_bound = 0;
    cfg_valid = 0;
    cfg_index = 0;
    cfg_data = 0;
    m_accel_p = 98042;
    m_accel_s = 98042;
    m_iner_max = 47828;
    m_iner_min = 19661;
    m_steps = 500;
    m_wrap = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_directed();
    test_random_phase(100, 0);
    test_wrap_mode();
    test_backpressure();
    test_random_configs();
    drain_pipe();
    if (fail_count == 0 && expected_q.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
